// ===== sv/pwlgc_pkg.sv =====
package pwlgc_pkg;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CORRECT = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ZERO_BP   = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;
  localparam logic [1:0] STATUS_SAT       = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         entry_index;
    logic signed [31:0] point_energy;
    logic signed [31:0] point_output;
    logic signed [31:0] energy_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] corrected_energy;
    logic [1:0]         status;
  } out_t;

endpackage

// ===== sv/pwlgc_ram.sv =====
module pwlgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/piecewise_linear_gain_correction.sv =====
// A load beat runs a 48-step serial divide; a rejected load or a pass-through
// correction goes straight to its result. A correction scans the breakpoints in
// the table memories in turn, runs a 33-step serial interpolation divide when the
// energy lies between two breakpoints, then multiplies and clamps.
// One beat is in work at a time. Reset clears the control state and the point
// count; the table memories hold no defined contents until loaded.
module piecewise_linear_gain_correction #(
  parameter int MAX_POINTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pwlgc_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pwlgc_pkg::out_t  out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [4:0]       cfg_data_i
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NW = (CW > 5) ? CW : 5;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_PREP, S_ITER, S_RATIO, S_MUL, S_SHIFT, S_SAT, S_DONE
  } state_e;

  state_e             state_q;
  logic [4:0]         cfg_q;
  logic               out_valid_q;
  pwlgc_pkg::out_t    out_q;

  logic               cmd_q;
  logic [AW-1:0]      k_q;
  logic [AW-1:0]      idx_q;
  logic signed [31:0] e_q;
  logic signed [31:0] lo_e_q, lo_r_q, hi_e_q, hi_r_q;
  logic [32:0]        c_q, b_q, r_q;
  logic [47:0]        dvd_q, q_q;
  logic [5:0]         cnt_q;
  logic               neg_q;
  logic signed [31:0] ratio_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] res_q;
  logic [1:0]         st_q;

  logic               accept;
  logic [NW-1:0]      piu_ext;
  logic [CW-1:0]      n_pts;
  logic               bad_index;

  logic signed [31:0] bp_rdata, r_rdata;
  logic [AW-1:0]      raddr;
  logic               mem_we;
  logic               found;
  logic               last;

  logic [34:0]        step_s, step_c1, step_c2;
  logic [32:0]        step_r;
  logic [1:0]         step_k;

  logic [31:0]        abs_op, abs_bp;
  logic signed [32:0] den, along, dr_up, dr_dn;
  logic               dr_neg;

  logic [63:0]        mag64;
  logic               sat;
  logic signed [31:0] sat_val;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  assign piu_ext   = NW'(cfg_q);
  assign n_pts     = (piu_ext > NW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(piu_ext);
  assign bad_index = 32'(in_data_i.entry_index) >= 32'(MAX_POINTS);

  assign raddr  = (state_q == S_IDLE) ? '0 : AW'(idx_q + AW'(1));
  assign mem_we = (state_q == S_SAT) && (cmd_q == pwlgc_pkg::CMD_LOAD);
  assign found  = e_q < bp_rdata;
  assign last   = CW'(idx_q) == (n_pts - CW'(1));

  pwlgc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_POINTS)
  ) u_bp_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (k_q),
    .wdata_i (e_q),
    .raddr_i (raddr),
    .rdata_o (bp_rdata)
  );

  pwlgc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_POINTS)
  ) u_ratio_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (k_q),
    .wdata_i (sat_val),
    .raddr_i (raddr),
    .rdata_o (r_rdata)
  );

  // One quotient step of floor(a * b / c), with the remainder kept below c.
  always_comb begin
    step_s  = {1'b0, r_q, 1'b0} + (dvd_q[47] ? {2'b00, b_q} : 35'd0);
    step_c1 = {2'b00, c_q};
    step_c2 = {1'b0, c_q, 1'b0};
    if (step_s >= step_c2) begin
      step_r = 33'(step_s - step_c2);
      step_k = 2'd2;
    end else if (step_s >= step_c1) begin
      step_r = 33'(step_s - step_c1);
      step_k = 2'd1;
    end else begin
      step_r = 33'(step_s);
      step_k = 2'd0;
    end
  end

  always_comb begin
    abs_op = in_data_i.point_output[31] ? 32'(-in_data_i.point_output)
                                        : 32'(in_data_i.point_output);
    abs_bp = in_data_i.point_energy[31] ? 32'(-in_data_i.point_energy)
                                        : 32'(in_data_i.point_energy);
    den    = 33'(hi_e_q) - 33'(lo_e_q);
    along  = 33'(e_q) - 33'(lo_e_q);
    dr_up  = 33'(hi_r_q) - 33'(lo_r_q);
    dr_dn  = 33'(lo_r_q) - 33'(hi_r_q);
    dr_neg = hi_r_q < lo_r_q;
    mag64  = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
    sat    = neg_q ? (q_q > 48'h0000_8000_0000) : (q_q > 48'h0000_7FFF_FFFF);
    if (sat) begin
      sat_val = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sat_val = neg_q ? 32'(-q_q[31:0]) : 32'(q_q[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cfg_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      if ((state_q == S_DONE) && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_data_i.cmd == pwlgc_pkg::CMD_LOAD) begin
              if (bad_index || in_data_i.point_energy == 32'sd0) begin
                state_q <= S_DONE;
              end else begin
                state_q <= S_ITER;
              end
            end else if (n_pts == '0) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (found) begin
            state_q <= (idx_q == '0) ? S_MUL : S_PREP;
          end else if (last) begin
            state_q <= S_MUL;
          end
        end
        S_PREP: begin
          state_q <= S_ITER;
        end
        S_ITER: begin
          if (cnt_q == 6'd1) begin
            state_q <= (cmd_q == pwlgc_pkg::CMD_LOAD) ? S_SAT : S_RATIO;
          end
        end
        S_RATIO: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_SHIFT;
        end
        S_SHIFT: begin
          state_q <= S_SAT;
        end
        S_SAT: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_q <= in_data_i.cmd;
          k_q   <= AW'(in_data_i.entry_index);
          idx_q <= '0;
          r_q   <= '0;
          q_q   <= '0;
          if (in_data_i.cmd == pwlgc_pkg::CMD_LOAD) begin
            e_q   <= in_data_i.point_energy;
            res_q <= '0;
            c_q   <= {1'b0, abs_bp};
            b_q   <= 33'd1;
            dvd_q <= {abs_op, 16'h0000};
            cnt_q <= 6'd48;
            neg_q <= in_data_i.point_output[31] ^ in_data_i.point_energy[31];
            if (bad_index) begin
              st_q <= pwlgc_pkg::STATUS_BAD_INDEX;
            end else if (in_data_i.point_energy == 32'sd0) begin
              st_q <= pwlgc_pkg::STATUS_ZERO_BP;
            end else begin
              st_q <= pwlgc_pkg::STATUS_OK;
            end
          end else begin
            e_q   <= in_data_i.energy_in;
            res_q <= in_data_i.energy_in;
            st_q  <= pwlgc_pkg::STATUS_OK;
          end
        end
      end
      S_SCAN: begin
        if (found) begin
          hi_e_q  <= bp_rdata;
          hi_r_q  <= r_rdata;
          ratio_q <= r_rdata;
        end else begin
          lo_e_q  <= bp_rdata;
          lo_r_q  <= r_rdata;
          ratio_q <= r_rdata;
          idx_q   <= AW'(idx_q + AW'(1));
        end
      end
      S_PREP: begin
        c_q   <= 33'(den);
        b_q   <= 33'(along);
        dvd_q <= {(dr_neg ? 33'(dr_dn) : 33'(dr_up)), 15'h0000};
        cnt_q <= 6'd33;
        neg_q <= dr_neg;
        r_q   <= '0;
        q_q   <= '0;
      end
      S_ITER: begin
        r_q   <= step_r;
        q_q   <= {q_q[46:0], 1'b0} + {46'd0, step_k};
        dvd_q <= {dvd_q[46:0], 1'b0};
        cnt_q <= cnt_q - 6'd1;
      end
      S_RATIO: begin
        ratio_q <= neg_q ? (lo_r_q - $signed(q_q[31:0])) : (lo_r_q + $signed(q_q[31:0]));
      end
      S_MUL: begin
        prod_q <= 64'(e_q) * 64'(ratio_q);
      end
      S_SHIFT: begin
        q_q   <= mag64[63:16];
        neg_q <= prod_q[63];
      end
      S_SAT: begin
        res_q <= (cmd_q == pwlgc_pkg::CMD_LOAD) ? 32'sd0 : sat_val;
        st_q  <= sat ? pwlgc_pkg::STATUS_SAT : pwlgc_pkg::STATUS_OK;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_q.corrected_energy <= res_q;
          out_q.status           <= st_q;
        end
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

endmodule
